// ----- rtl/adc_average_scale_deadband_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ADC averaging unit
// Clocked concurrent checks with a synchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef ADC_AVERAGE_SCALE_DEADBAND_UNIT_ASSERT_SVH
`define ADC_AVERAGE_SCALE_DEADBAND_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define AASD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define AASD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/aasd_pkg.sv -----
// ----------------------------------------------------------------------------
// aasd_pkg
// Shared widths, defaults and constants of the ADC averaging unit.
// ----------------------------------------------------------------------------
package aasd_pkg;

    // Word field widths
    localparam int RAW_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int DB_W    = 8;

    // Default build-time configuration
    localparam int WINDOW_DEPTH_DEF = 8;
    localparam int FULL_SCALE_DEF   = 4095;

    // Output range is 0..255, so scaling multiplies by 2^8 - 1
    localparam int SCALE_SHIFT = 8;

    // Deadband value after reset
    localparam logic [DB_W-1:0] DEADBAND_RST = DB_W'(2);

    typedef logic [RAW_W-1:0]   t_raw;
    typedef logic [LEVEL_W-1:0] t_level;

endpackage

// ----- rtl/aasd_ifs.sv -----
// ----------------------------------------------------------------------------
// aasd channel interfaces
// Valid/ready channels for raw sample words and level words.
// ----------------------------------------------------------------------------
interface aasd_sample_if;
    logic              valid;
    logic              ready;
    aasd_pkg::t_raw    raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface aasd_level_if;
    logic              valid;
    logic              ready;
    aasd_pkg::t_level  level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

// ----- rtl/adc_average_scale_deadband_unit.sv -----
// ----------------------------------------------------------------------------
// adc_average_scale_deadband_unit
// Moving average of ADC words, scaled to 0..255, with a deadband on the level.
// Channels: i_sample carries one raw_sample word per item (valid/ready);
// o_level returns one 8-bit level word per accepted sample, in order.
// i_cfg_we / i_cfg_wdata write the deadband; write only while the unit is idle.
// Throughput: one word per cycle while o_level is not stalled, set by the
// five-register pipeline (input, running sum, average multiply, scale
// multiply, level) that advances as one unit.
// Stall: when the receiver holds ready low with a word waiting, the whole
// pipeline holds and i_sample.ready drops in the same cycle.
// Reset (synchronous, active low): pipeline empty, window unprimed, sum and
// held level zero, deadband 2. The first sample fills the window; no clearing pass.
// ----------------------------------------------------------------------------
`include "adc_average_scale_deadband_unit_assert.svh"

module adc_average_scale_deadband_unit #(
    parameter int WINDOW_DEPTH = aasd_pkg::WINDOW_DEPTH_DEF,
    parameter int FULL_SCALE   = aasd_pkg::FULL_SCALE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [aasd_pkg::DB_W-1:0]  i_cfg_wdata,
    aasd_sample_if.sink                i_sample,
    aasd_level_if.source               o_level
);

    localparam int LVL_W  = aasd_pkg::LEVEL_W;
    localparam int SMP_W  = $clog2(FULL_SCALE + 1);
    localparam int TOT_W  = SMP_W + $clog2(WINDOW_DEPTH);
    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    // Sum / depth as multiply by rounded-up reciprocal, exact for all sums
    localparam int M1_W = TOT_W + 1;
    localparam int K1   = TOT_W + $clog2(WINDOW_DEPTH);
    localparam int P1_W = TOT_W + M1_W;
    localparam longint unsigned M1_FULL =
        ((64'd1 << K1) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
    localparam logic [M1_W-1:0] M1 = M1_W'(M1_FULL);

    // avg * 255 / full scale, same reciprocal scheme
    localparam int Y_W  = SMP_W + aasd_pkg::SCALE_SHIFT;
    localparam int M2_W = Y_W + 1;
    localparam int K2   = Y_W + $clog2(FULL_SCALE);
    localparam int P2_W = Y_W + M2_W;
    localparam longint unsigned M2_FULL =
        ((64'd1 << K2) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
    localparam logic [M2_W-1:0] M2 = M2_W'(M2_FULL);

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);
    localparam logic [TOT_W-1:0]  TOT_MAX   =
        TOT_W'(FULL_SCALE) * TOT_W'(WINDOW_DEPTH);

    // Pipeline control
    logic               w_adv;
    logic               r_v1, r_v2, r_v3, r_v4, r_out_valid;
    logic               w_step;

    // Window state
    logic [SMP_W-1:0]   r_window [WINDOW_DEPTH];
    logic [SMP_W-1:0]   r_rd;
    logic [SMP_W-1:0]   r_prime;
    logic               r_primed;
    logic               r_lap_done;
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  w_slot_nxt;
    logic [TOT_W-1:0]   r_total;
    logic [TOT_W-1:0]   n_total;
    logic [SMP_W-1:0]   w_old;

    // Datapath registers
    logic [SMP_W-1:0]   r1_smp;
    logic [SMP_W-1:0]   w_clamp;
    logic [TOT_W-1:0]   r2_total;
    logic               r2_prime, r3_prime, r4_prime;
    logic [P1_W-1:0]    w_prod1;
    logic [SMP_W-1:0]   r3_avg;
    logic [Y_W-1:0]     w_y;
    logic [P2_W-1:0]    w_prod2;
    logic [LVL_W-1:0]   r4_scaled;
    logic [LVL_W-1:0]   r_held;
    logic [LVL_W-1:0]   n_held;
    logic [LVL_W-1:0]   w_diff;
    logic [LVL_W-1:0]   r_out_level;
    logic [aasd_pkg::DB_W-1:0] r_deadband;

    // Advance the whole pipeline unless a finished word is stalled
    assign w_adv          = !r_out_valid || o_level.ready;
    assign i_sample.ready = w_adv;
    assign w_step         = r_v1 && w_adv;

    assign o_level.valid  = r_out_valid;
    assign o_level.level  = r_out_level;

    // Clamp the raw word to full scale
    assign w_clamp = (i_sample.raw_sample > aasd_pkg::RAW_W'(FULL_SCALE))
                   ? SMP_W'(FULL_SCALE) : i_sample.raw_sample[SMP_W-1:0];

    // Valid bits and deadband register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
            r_deadband  <= aasd_pkg::DEADBAND_RST;
        end else begin
            if (w_adv) begin
                r_v1        <= i_sample.valid;
                r_v2        <= r_v1;
                r_v3        <= r_v2;
                r_v4        <= r_v3;
                r_out_valid <= r_v4;
            end
            if (i_cfg_we) begin
                r_deadband <= i_cfg_wdata;
            end
        end
    end

    // Stage 1: capture the clamped sample
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_smp <= w_clamp;
        end
    end

    // Entries not yet overwritten since priming still hold the priming sample
    assign w_old      = r_lap_done ? r_rd : r_prime;
    assign w_slot_nxt = (r_slot == SLOT_LAST) ? '0 : r_slot + SLOT_W'(1);

    always_comb begin
        if (!r_primed) begin
            n_total = TOT_W'(r1_smp) * TOT_W'(WINDOW_DEPTH);
        end else begin
            n_total = r_total - TOT_W'(w_old) + TOT_W'(r1_smp);
        end
    end

    // Stage 2: window state and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed   <= 1'b0;
            r_lap_done <= 1'b0;
            r_slot     <= '0;
            r_total    <= '0;
        end else if (w_step) begin
            r_primed <= 1'b1;
            r_total  <= n_total;
            if (r_primed) begin
                r_slot <= w_slot_nxt;
                if (r_slot == SLOT_LAST) begin
                    r_lap_done <= 1'b1;
                end
            end
        end
    end

    // Window memory: write the oldest slot, prefetch the next one
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            if (!r_primed) begin
                r_prime <= r1_smp;
            end else begin
                r_window[r_slot] <= r1_smp;
                if (WINDOW_DEPTH == 1) begin
                    r_rd <= r1_smp;
                end else begin
                    r_rd <= r_window[w_slot_nxt];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r2_total <= n_total;
            r2_prime <= !r_primed;
        end
    end

    // Stage 3: average = sum / depth
    assign w_prod1 = P1_W'(r2_total) * P1_W'(M1);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_avg   <= w_prod1[K1 +: SMP_W];
            r3_prime <= r2_prime;
        end
    end

    // Stage 4: scaled = avg * 255 / full scale
    assign w_y     = (Y_W'(r3_avg) << aasd_pkg::SCALE_SHIFT) - Y_W'(r3_avg);
    assign w_prod2 = P2_W'(w_y) * P2_W'(M2);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_scaled <= w_prod2[K2 +: LVL_W];
            r4_prime  <= r3_prime;
        end
    end

    // Stage 5: deadband test on the held level
    assign w_diff = (r4_scaled >= r_held) ? r4_scaled - r_held : r_held - r4_scaled;

    always_comb begin
        if (r4_prime || (w_diff >= r_deadband)) begin
            n_held = r4_scaled;
        end else begin
            n_held = r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (r_v4 && w_adv) begin
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v4 && w_adv) begin
            r_out_level <= n_held;
        end
    end

    // Checks
    `AASD_ASSERT_NEXT(a_held_hold, i_clk, i_rst_n, !(r_v4 && w_adv), $stable(r_held), "held level changed without a word")
    `AASD_ASSERT_NOW(a_total_range, i_clk, i_rst_n, 1'b1, r_total <= TOT_MAX, "running sum beyond full window")
    `AASD_ASSERT_NOW(a_lap_primed, i_clk, i_rst_n, r_lap_done || (r_slot != '0), r_primed, "window advanced before priming")

endmodule
